### rtl/mfb_pkg.sv
package mfb_pkg;

  localparam int Columns = 128;
  localparam int Rows = 64;
  localparam int StoreBytes = 1024;

  typedef enum logic [2:0] {
    KIND_POINT = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_RECT  = 3'd2,
    KIND_FILL  = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  // One queued command as the back end sees it.
  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] x_first;
    logic [11:0] y_first;
    logic [11:0] x_second;
    logic [11:0] y_second;
    logic        dot_value;
    logic [7:0]  fill_byte;
    logic [9:0]  read_index;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_RD,
    ST_WR,
    ST_RESULT
  } state_t;

endpackage

### rtl/monochrome_framebuffer_raster.sv
// 128x64 one-bit page framebuffer raster engine.
// Input channel: one command per beat (in_valid/in_ready): point, line,
// rectangle fill, whole-store fill or byte read. Unknown kinds are dropped.
// Output channel: one beat (out_valid/out_ready) for each read command only.
// A two-entry command queue sits between the front end and the executor,
// so new beats are taken while the executor draws or a result waits.
// Each line or rectangle pixel takes a walk step, a read of its page byte
// and a write back of the modified byte; a point skips the walk step.
// A read fetches its byte, raises out_valid with it and frees the executor
// once the beat is taken.
// After reset the executor sweeps the 1024-byte store to zero; commands
// are queued meanwhile but not executed.
// When the receiver stalls, the result beat holds and the executor waits;
// the queue keeps taking commands until it is full.
module monochrome_framebuffer_raster (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic signed [11:0] in_x_first,
  input  logic signed [11:0] in_y_first,
  input  logic signed [11:0] in_x_second,
  input  logic signed [11:0] in_y_second,
  input  logic        in_dot_value,
  input  logic [7:0]  in_fill_byte,
  input  logic [9:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data
);

  mfb_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  assign in_cmd = '{kind: in_kind, x_first: in_x_first, y_first: in_y_first,
                    x_second: in_x_second, y_second: in_y_second,
                    dot_value: in_dot_value, fill_byte: in_fill_byte,
                    read_index: in_read_index};

  mfb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  mfb_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_cmd), .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data)
  );

endmodule

### rtl/mfb_front.sv
// Accepts command beats, drops unknown kinds and holds up to two commands.
module mfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfb_pkg::cmd_t     in_cmd,
  output logic              q_valid,
  input  logic              q_ready,
  output mfb_pkg::cmd_t     q_cmd
);

  mfb_pkg::cmd_t slot_r [2];
  logic [1:0] count_r, count_nxt;
  logic       head_r, head_nxt, tail_r, tail_nxt;
  logic       push, pop, known;

  assign in_ready = (count_r != 2'd2);
  assign known    = (in_cmd.kind <= 3'(mfb_pkg::KIND_READ));
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot_r[head_r];

  always_comb begin
    count_nxt = count_r + 2'(push) - 2'(pop);
    head_nxt  = head_r ^ pop;
    tail_nxt  = tail_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= in_cmd;
    end
  end

endmodule

### rtl/mfb_back.sv
// Executes commands against the page store, one pixel (read then write) at a time.
module mfb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  mfb_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_read_data
);

  logic [7:0] mem [mfb_pkg::StoreBytes];

  mfb_pkg::state_t state_r, state_nxt;
  mfb_pkg::kind_t  kind_r, kind_nxt;
  logic [7:0]  fillv_r, fillv_nxt;
  // Line walk: a = major, b = minor coordinate (wide enough for any wrap).
  logic [12:0] a_r, a_nxt, b_r, b_nxt, b_end_r, b_end_nxt;
  logic [12:0] major_r, major_nxt, minor_r, minor_nxt;
  logic [13:0] err_r, err_nxt;
  logic [12:0] left_r, left_nxt;
  logic        xmaj_r, xmaj_nxt;
  // Rectangle walk.
  logic [7:0]  rx_r, rx_nxt, ry_r, ry_nxt, rya_r, rya_nxt, rxb_r, rxb_nxt, ryb_r, ryb_nxt;
  logic [9:0]  clr_r, clr_nxt;
  // Pending pixel.
  logic [7:0]  px_r, px_nxt, py_r, py_nxt;
  logic        pon_r, pon_nxt;
  logic        from_walk_r, from_walk_nxt;
  logic [7:0]  rdata_r;
  logic [7:0]  out_r, out_nxt;
  logic [9:0]  ridx_r;

  logic        mem_we;
  logic [9:0]  mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata;

  logic signed [12:0] x1, y1, x2, y2, dx, dy;
  logic        xm;
  logic [12:0] a1, a2, b1, b2;
  logic [12:0] nb;
  logic [13:0] ne;
  logic [9:0]  pix_addr;
  logic [7:0]  pix_mask;

  assign pix_addr = {px_r[6:0], 3'd7 - py_r[5:3]};
  assign pix_mask = 8'h80 >> py_r[2:0];

  assign out_valid     = (state_r == mfb_pkg::ST_RESULT);
  assign out_read_data = out_r;

  always_comb begin
    x1 = {q_cmd.x_first[11], q_cmd.x_first};
    y1 = {q_cmd.y_first[11], q_cmd.y_first};
    x2 = {q_cmd.x_second[11], q_cmd.x_second};
    y2 = {q_cmd.y_second[11], q_cmd.y_second};
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    xm = (dy < dx);
    a1 = xm ? x1 : y1;
    a2 = xm ? x2 : y2;
    b1 = xm ? y1 : x1;
    b2 = xm ? y2 : x2;
  end

  always_comb begin
    state_nxt = state_r;   kind_nxt = kind_r;
    fillv_nxt = fillv_r;   a_nxt = a_r;         b_nxt = b_r;
    b_end_nxt = b_end_r;   major_nxt = major_r; minor_nxt = minor_r;
    err_nxt = err_r;       left_nxt = left_r;   xmaj_nxt = xmaj_r;
    rx_nxt = rx_r;         ry_nxt = ry_r;       rya_nxt = rya_r;
    rxb_nxt = rxb_r;       ryb_nxt = ryb_r;     clr_nxt = clr_r;
    px_nxt = px_r;         py_nxt = py_r;       pon_nxt = pon_r;
    from_walk_nxt = from_walk_r;
    out_nxt = out_r;
    q_ready = 1'b0;
    mem_we = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = fillv_r;
    mem_raddr = pix_addr;
    nb = b_r;
    ne = err_r;
    unique case (state_r)
      mfb_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        clr_nxt = clr_r + 10'd1;
        if (clr_r == 10'(mfb_pkg::StoreBytes - 1)) state_nxt = mfb_pkg::ST_IDLE;
      end
      mfb_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          kind_nxt = mfb_pkg::kind_t'(q_cmd.kind);
          unique case (mfb_pkg::kind_t'(q_cmd.kind))
            mfb_pkg::KIND_POINT: begin
              px_nxt = q_cmd.x_first[7:0]; py_nxt = q_cmd.y_first[7:0];
              pon_nxt = q_cmd.dot_value; from_walk_nxt = 1'b0;
              state_nxt = mfb_pkg::ST_RD;
            end
            mfb_pkg::KIND_LINE: begin
              xmaj_nxt = xm;
              major_nxt = xm ? dx : dy;
              minor_nxt = xm ? dy : dx;
              err_nxt = {1'b0, xm ? dy : dx};
              if ($signed(a1) > $signed(a2)) begin
                a_nxt = a2; b_nxt = b2; b_end_nxt = b1;
              end else begin
                a_nxt = a1; b_nxt = b1; b_end_nxt = b2;
              end
              left_nxt = xm ? dx : dy;
              state_nxt = mfb_pkg::ST_WALK;
            end
            mfb_pkg::KIND_RECT: begin
              rx_nxt = q_cmd.x_first[7:0];
              ry_nxt = q_cmd.y_first[7:0];  rya_nxt = q_cmd.y_first[7:0];
              rxb_nxt = q_cmd.x_second[7:0];
              ryb_nxt = q_cmd.y_second[7:0];
              pon_nxt = q_cmd.dot_value;
              // Empty range in either axis draws nothing.
              if (q_cmd.x_first[7:0] <= q_cmd.x_second[7:0] &&
                  q_cmd.y_first[7:0] <= q_cmd.y_second[7:0]) begin
                state_nxt = mfb_pkg::ST_WALK;
              end
            end
            mfb_pkg::KIND_FILL: begin
              fillv_nxt = q_cmd.fill_byte; clr_nxt = 10'd0;
              state_nxt = mfb_pkg::ST_CLEAR;
            end
            mfb_pkg::KIND_READ: begin
              state_nxt = mfb_pkg::ST_RD;
              from_walk_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      mfb_pkg::ST_WALK: begin
        from_walk_nxt = 1'b1;
        state_nxt = mfb_pkg::ST_RD;
        if (kind_r == mfb_pkg::KIND_LINE) begin
          if ($signed(err_r) >= $signed({1'b0, major_r})) begin
            ne = err_r - {1'b0, major_r};
            nb = ($signed(b_r) < $signed(b_end_r)) ? b_r + 13'd1 : b_r - 13'd1;
          end
          err_nxt = ne + {1'b0, minor_r};
          b_nxt = nb;
          a_nxt = a_r + 13'd1;
          px_nxt = xmaj_r ? a_r[7:0] : nb[7:0];
          py_nxt = xmaj_r ? nb[7:0] : a_r[7:0];
          pon_nxt = 1'b1;
        end else begin
          px_nxt = rx_r; py_nxt = ry_r;
        end
      end
      mfb_pkg::ST_RD: begin
        if (kind_r == mfb_pkg::KIND_READ) mem_raddr = ridx_r;
        state_nxt = mfb_pkg::ST_WR;
      end
      mfb_pkg::ST_WR: begin
        if (kind_r == mfb_pkg::KIND_READ) begin
          out_nxt = rdata_r;
          state_nxt = mfb_pkg::ST_RESULT;
        end else begin
          mem_waddr = pix_addr;
          mem_wdata = pon_r ? (rdata_r | pix_mask) : (rdata_r & ~pix_mask);
          mem_we = (px_r < 8'(mfb_pkg::Columns)) && (py_r < 8'(mfb_pkg::Rows));
          state_nxt = mfb_pkg::ST_IDLE;
          if (from_walk_r) begin
            state_nxt = mfb_pkg::ST_WALK;
            if (kind_r == mfb_pkg::KIND_LINE) begin
              left_nxt = left_r - 13'd1;
              if (left_r == 13'd0) state_nxt = mfb_pkg::ST_IDLE;
            end else begin
              if (ry_r == ryb_r) begin
                if (rx_r == rxb_r) state_nxt = mfb_pkg::ST_IDLE;
                rx_nxt = rx_r + 8'd1;
                ry_nxt = rya_r;
              end else begin
                ry_nxt = ry_r + 8'd1;
              end
            end
          end
        end
      end
      mfb_pkg::ST_RESULT: begin
        if (out_ready) state_nxt = mfb_pkg::ST_IDLE;
      end
      default: state_nxt = mfb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == mfb_pkg::ST_IDLE && q_valid) begin
      ridx_r <= q_cmd.read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfb_pkg::ST_CLEAR;
      clr_r   <= 10'd0;
      fillv_r <= 8'd0;
      kind_r  <= mfb_pkg::KIND_POINT;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      fillv_r <= fillv_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;           b_r <= b_nxt;
    b_end_r <= b_end_nxt;   major_r <= major_nxt; minor_r <= minor_nxt;
    err_r <= err_nxt;       left_r <= left_nxt;   xmaj_r <= xmaj_nxt;
    rx_r <= rx_nxt;         ry_r <= ry_nxt;       rya_r <= rya_nxt;
    rxb_r <= rxb_nxt;       ryb_r <= ryb_nxt;
    px_r <= px_nxt;         py_r <= py_nxt;       pon_r <= pon_nxt;
    from_walk_r <= from_walk_nxt;
    out_r <= out_nxt;
  end

endmodule

### dv/tb_monochrome_framebuffer_raster.sv
module tb_monochrome_framebuffer_raster;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic signed [11:0] in_x_first;
  logic signed [11:0] in_y_first;
  logic signed [11:0] in_x_second;
  logic signed [11:0] in_y_second;
  logic        in_dot_value;
  logic [7:0]  in_fill_byte;
  logic [9:0]  in_read_index;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;

  // Kinds above the last defined one are dropped by the block.
  localparam logic [2:0] KindSpareLo = 3'd5;
  localparam logic [2:0] KindSpareHi = 3'd7;

  localparam int RandomCommands = 1600;
  localparam int HoldOffCycles = 3000;
  localparam int HoldOffAt = 400;
  localparam int DrainCycles = 3000;

  monochrome_framebuffer_raster dut (.*);

  // The predicted contents of the 1024-byte page store, and the read
  // bytes that are still on their way out of the block.
  logic [7:0]     page_bytes [mfb_pkg::StoreBytes];
  logic [7:0]     pending_reads [$];
  mfb_pkg::cmd_t  cmd_queue [$];

  int failures = 0;
  int beats_in = 0;
  int beats_out = 0;
  int kind_seen [8];
  bit in_fire = 0;
  bit quiet_stretch = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // One pixel write. Only the low byte of each coordinate counts, and
  // anything off the 128x64 panel is dropped.
  function automatic void set_pixel(int x, int y, bit on);
    logic [7:0] px;
    logic [7:0] py;
    int idx;
    px = x[7:0];
    py = y[7:0];
    if (px >= mfb_pkg::Columns || py >= mfb_pkg::Rows) return;
    idx = px * 8 + (7 - py / 8);
    page_bytes[idx][7 - py % 8] = on;
  endfunction

  // Line walk: the major axis is the longer one (y on a tie), endpoints
  // are ordered so the major coordinate ascends, and the minor coordinate
  // steps before the pixel whenever the error reaches the major length.
  // On a tie this steps before the very first pixel, which also moves a
  // zero-length line one to the left.
  function automatic void trace_line(int x1, int y1, int x2, int y2);
    int dx;
    int dy;
    bit x_major;
    int major;
    int minor;
    int a1;
    int a2;
    int b1;
    int b2;
    int t;
    int err;
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    x_major = dy < dx;
    major = x_major ? dx : dy;
    minor = x_major ? dy : dx;
    a1 = x_major ? x1 : y1;
    a2 = x_major ? x2 : y2;
    b1 = x_major ? y1 : x1;
    b2 = x_major ? y2 : x2;
    if (a1 > a2) begin
      t = a1; a1 = a2; a2 = t;
      t = b1; b1 = b2; b2 = t;
    end
    err = minor;
    for (int n = 0; n <= major; n++) begin
      if (err >= major) begin
        err -= major;
        b1 += (b1 < b2) ? 1 : -1;
      end
      err += minor;
      if (x_major) set_pixel(a1, b1, 1'b1);
      else set_pixel(b1, a1, 1'b1);
      a1++;
    end
  endfunction

  // Applies one accepted command to the predicted store.
  function automatic void apply_command(mfb_pkg::cmd_t c);
    int xa;
    int xb;
    int ya;
    int yb;
    case (c.kind)
      mfb_pkg::KIND_POINT:
        set_pixel($signed(c.x_first), $signed(c.y_first), c.dot_value);
      mfb_pkg::KIND_LINE:
        trace_line($signed(c.x_first), $signed(c.y_first),
                   $signed(c.x_second), $signed(c.y_second));
      mfb_pkg::KIND_RECT: begin
        // Bounds are 8-bit; a far corner of 255 simply stops at 255.
        xa = c.x_first[7:0];
        xb = c.x_second[7:0];
        ya = c.y_first[7:0];
        yb = c.y_second[7:0];
        for (int x = xa; x <= xb; x++)
          for (int y = ya; y <= yb; y++)
            set_pixel(x, y, c.dot_value);
      end
      mfb_pkg::KIND_FILL: foreach (page_bytes[i]) page_bytes[i] = c.fill_byte;
      mfb_pkg::KIND_READ: pending_reads.push_back(page_bytes[c.read_index]);
      default: ;
    endcase
  endfunction

  function automatic mfb_pkg::cmd_t make_cmd(logic [2:0] kind, int xf, int yf, int xs,
                                             int ys, bit dot, int fill, int ridx);
    mfb_pkg::cmd_t c;
    c.kind = kind;
    c.x_first = xf[11:0];
    c.y_first = yf[11:0];
    c.x_second = xs[11:0];
    c.y_second = ys[11:0];
    c.dot_value = dot;
    c.fill_byte = fill[7:0];
    c.read_index = ridx[9:0];
    return c;
  endfunction

  // A coordinate that mostly lands on or just around the panel.
  function automatic int near_coord();
    return $urandom_range(175) - 16;
  endfunction

  function automatic mfb_pkg::cmd_t random_cmd();
    int pick;
    int xf;
    int yf;
    mfb_pkg::cmd_t c;
    pick = $urandom_range(99);
    c = make_cmd(mfb_pkg::KIND_READ, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(1), $urandom, $urandom);
    if (pick < 25) begin
      c.kind = mfb_pkg::KIND_POINT;
      if ($urandom_range(9) != 0) begin
        c.x_first = 12'(near_coord());
        c.y_first = 12'(near_coord());
      end
    end else if (pick < 45) begin
      c.kind = mfb_pkg::KIND_LINE;
      // Long lines are drawn pixel by pixel, so most stay near the panel
      // and only a few use the full coordinate range.
      if ($urandom_range(19) != 0) begin
        c.x_first = 12'(near_coord());
        c.y_first = 12'(near_coord());
        c.x_second = 12'(near_coord());
        c.y_second = 12'(near_coord());
      end
    end else if (pick < 57) begin
      c.kind = mfb_pkg::KIND_RECT;
      // Small rectangles, one in four at a random position; the low byte of the far
      // corner may fall below the near one, which draws nothing.
      xf = $urandom;
      yf = $urandom;
      if ($urandom_range(3) != 0) begin
        xf = near_coord();
        yf = near_coord();
      end
      c.x_first = 12'(xf);
      c.y_first = 12'(yf);
      c.x_second = 12'(xf + $urandom_range(14) - 2);
      c.y_second = 12'(yf + $urandom_range(14) - 2);
    end else if (pick < 60) begin
      c.kind = mfb_pkg::KIND_FILL;
    end else if (pick < 95) begin
      c.kind = mfb_pkg::KIND_READ;
      // Reads use an index anywhere in the whole store.
      if ($urandom_range(1) != 0) begin
        c.read_index = 10'($urandom_range(mfb_pkg::StoreBytes - 1));
      end
    end else begin
      c.kind = 3'($urandom_range(KindSpareHi, KindSpareLo));
    end
    return c;
  endfunction

  // Driver: presents one beat at a time from the command queue. A beat
  // stays on the port until the monitor has seen it accepted.
  always @(negedge clk) begin
    mfb_pkg::cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (cmd_queue.size() > 0 && (quiet_stretch || $urandom_range(99) >= 20)) begin
        c = cmd_queue.pop_front();
        in_valid <= 1'b1;
        in_kind <= c.kind;
        in_x_first <= c.x_first;
        in_y_first <= c.y_first;
        in_x_second <= c.x_second;
        in_y_second <= c.y_second;
        in_dot_value <= c.dot_value;
        in_fill_byte <= c.fill_byte;
        in_read_index <= c.read_index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off while the
  // sender keeps going so that the command queue fills and in_ready drops.
  int hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!hold_done && beats_in >= HoldOffAt) begin
      hold_done <= 1'b1;
      hold_left <= HoldOffCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_stretch || $urandom_range(99) >= 20;
    end
  end

  // Monitor: every accepted command updates the prediction in order, and
  // every result beat is checked against the oldest predicted read.
  always @(posedge clk) begin
    logic [7:0] want;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      apply_command(make_cmd(in_kind, in_x_first, in_y_first, in_x_second, in_y_second,
                             in_dot_value, in_fill_byte, in_read_index));
      kind_seen[in_kind]++;
      beats_in++;
      quiet_stretch <= beats_in >= 900 && beats_in < 1150;
    end
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (pending_reads.size() == 0) begin
        $error("read_data: no read outstanding, got %0d", out_read_data);
        failures++;
      end else begin
        want = pending_reads.pop_front();
        if (out_read_data !== want) begin
          $error("read_data: expected %0d, got %0d", want, out_read_data);
          failures++;
        end
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_kind = mfb_pkg::KIND_POINT;
    in_x_first = '0;
    in_y_first = '0;
    in_x_second = '0;
    in_y_second = '0;
    in_dot_value = 1'b0;
    in_fill_byte = '0;
    in_read_index = '0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    foreach (page_bytes[i]) page_bytes[i] = '0;

    // Directed part: panel edges, just-off-panel points, wrap-around,
    // the tied-length and zero-length line cases, a rectangle that ends
    // at 255, an empty rectangle, a whole fill and the dropped kinds.
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_POINT, 0, 0, 0, 0, 1, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_POINT, 127, 63, 0, 0, 1, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_POINT, 128, 64, 0, 0, 1, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_POINT, -2048 + 5, 2047, 0, 0, 1, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 7));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1016));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_LINE, 10, 10, 20, 20, 0, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_LINE, 30, 5, 30, 5, 0, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_LINE, 100, 50, 5, 40, 0, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_LINE, 60, 63, 50, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_LINE, -300, 20, 400, 30, 0, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 85));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 240));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_RECT, 120, 60, 255, 255, 1, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_RECT, 40, 20, 30, 25, 1, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_RECT, 0, 0, 3, 9, 0, 0, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1023));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 6));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_FILL, 0, 0, 0, 0, 0, 8'hA5, 0));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_POINT, 64, 32, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindSpareLo, 1, 1, 1, 1, 1, 8'hFF, 1023));
    cmd_queue.push_back(make_cmd(KindSpareHi, -1, -1, -1, -1, 1, 8'hFF, 1023));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 512 + 3));
    cmd_queue.push_back(make_cmd(mfb_pkg::KIND_FILL, 0, 0, 0, 0, 0, 8'h00, 0));
    repeat (RandomCommands) cmd_queue.push_back(random_cmd());

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    wait (cmd_queue.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (pending_reads.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d commands: %0d points, %0d lines, %0d rectangles, %0d fills,",
             beats_in, kind_seen[mfb_pkg::KIND_POINT], kind_seen[mfb_pkg::KIND_LINE],
             kind_seen[mfb_pkg::KIND_RECT], kind_seen[mfb_pkg::KIND_FILL]);
    $display("%0d reads checked on %0d result beats, with one long receiver hold-off.",
             kind_seen[mfb_pkg::KIND_READ], beats_out);
    if (failures == 0 && pending_reads.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
